// ===== rtl/rexp_pkg.sv =====
// Shared types, constants and the arctangent table of the rotation exponential map.
package rexp_pkg;

    localparam int SQRT_STEPS    = 32;
    localparam int CORDIC_STAGES = 30;
    localparam int DIV_STEPS     = 38;

    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

    typedef struct packed {
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } vec_t;

    typedef struct packed {
        logic [31:0] theta;
        vec_t        vec;
    } side_t;

    typedef struct packed {
        logic [31:0] angle;
        logic [31:0] qz;
        logic [31:0] qy;
        logic [31:0] qx;
        logic [31:0] qw;
    } result_t;

    function automatic logic [31:0] atan_q30(input int unsigned i);
        logic [31:0] a;
        begin
            case (i)
                0:  a = 32'h3243F6A8;
                1:  a = 32'h1DAC6705;
                2:  a = 32'h0FADBAFC;
                3:  a = 32'h07F56EA6;
                4:  a = 32'h03FEAB76;
                5:  a = 32'h01FFD55B;
                6:  a = 32'h00FFFAAA;
                7:  a = 32'h007FFF55;
                8:  a = 32'h003FFFEA;
                9:  a = 32'h001FFFFD;
                10: a = 32'h000FFFFF;
                11: a = 32'h0007FFFF;
                12: a = 32'h0003FFFF;
                13: a = 32'h0001FFFF;
                14: a = 32'h0000FFFF;
                15: a = 32'h00007FFF;
                16: a = 32'h00003FFF;
                17: a = 32'h00001FFF;
                18: a = 32'h00000FFF;
                19: a = 32'h000007FF;
                20: a = 32'h000003FF;
                21: a = 32'h000001FF;
                22: a = 32'h000000FF;
                23: a = 32'h0000007F;
                24: a = 32'h0000003F;
                25: a = 32'h0000001F;
                26: a = 32'h0000000F;
                27: a = 32'h00000008;
                28: a = 32'h00000004;
                29: a = 32'h00000002;
                default: a = 32'h00000000;
            endcase
            return a;
        end
    endfunction

endpackage

// ===== rtl/rexp_norm.sv =====
// Euclidean norm of the rotation vector: squares, sum and a bit-per-stage square root.
module rexp_norm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  rexp_pkg::vec_t  in_vec,
    output logic            out_valid,
    output rexp_pkg::side_t out_side
);

    logic [31:0] mag [3];
    logic [63:0] sq_reg [3];
    logic        va_reg;
    rexp_pkg::vec_t veca_reg;

    logic [63:0]    rem_reg [0:rexp_pkg::SQRT_STEPS];
    logic [63:0]    res_reg [0:rexp_pkg::SQRT_STEPS];
    logic           vld_reg [0:rexp_pkg::SQRT_STEPS];
    rexp_pkg::vec_t vec_reg [0:rexp_pkg::SQRT_STEPS];

    logic            out_valid_reg;
    rexp_pkg::side_t out_side_reg;

    always_comb
    begin
        mag[0] = in_vec.x[31] ? (~in_vec.x + 32'd1) : in_vec.x;
        mag[1] = in_vec.y[31] ? (~in_vec.y + 32'd1) : in_vec.y;
        mag[2] = in_vec.z[31] ? (~in_vec.z + 32'd1) : in_vec.z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg     <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            va_reg     <= in_valid;
            vld_reg[0] <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k] <= mag[k] * mag[k];
            end
            veca_reg   <= in_vec;
            rem_reg[0] <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            res_reg[0] <= '0;
            vec_reg[0] <= veca_reg;
        end
    end

    // One root bit per stage, most significant first.
    for (genvar j = 0; j < rexp_pkg::SQRT_STEPS; j++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] trial;
        logic [63:0] rem_next;
        logic [63:0] res_next;

        always_comb
        begin
            trial = res_reg[j] + BIT;
            if (rem_reg[j] >= trial)
            begin
                rem_next = rem_reg[j] - trial;
                res_next = (res_reg[j] >> 1) + BIT;
            end
            else
            begin
                rem_next = rem_reg[j];
                res_next = res_reg[j] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= rem_next;
                res_reg[j+1] <= res_next;
                vec_reg[j+1] <= vec_reg[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[rexp_pkg::SQRT_STEPS];
        end
    end

    // Round to nearest: the remainder exceeds the root exactly when the upper half wins.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_side_reg.theta <= res_reg[rexp_pkg::SQRT_STEPS][31:0]
                + {31'd0, (rem_reg[rexp_pkg::SQRT_STEPS] > res_reg[rexp_pkg::SQRT_STEPS])};
            out_side_reg.vec <= vec_reg[rexp_pkg::SQRT_STEPS];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_side  = out_side_reg;

endmodule

// ===== rtl/rexp_cordic.sv =====
// Range reduction and rotation-mode CORDIC giving cos and sin of half the angle.
module rexp_cordic (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  rexp_pkg::side_t         in_side,
    output logic                    out_valid,
    output logic signed [33:0]      out_cx,
    output logic signed [33:0]      out_cy,
    output rexp_pkg::side_t         out_side
);

    localparam int N = rexp_pkg::CORDIC_STAGES;

    logic signed [35:0] phi0;
    logic signed [35:0] phi1_reg;
    logic               v1_reg;
    rexp_pkg::side_t    side1_reg;

    logic signed [33:0] cx_reg   [0:N];
    logic signed [33:0] cy_reg   [0:N];
    logic signed [35:0] phi_reg  [0:N];
    logic               flip_reg [0:N];
    logic               vld_reg  [0:N];
    rexp_pkg::side_t    side_reg [0:N];

    logic               out_valid_reg;
    logic signed [33:0] out_cx_reg;
    logic signed [33:0] out_cy_reg;
    rexp_pkg::side_t    out_side_reg;

    logic signed [35:0] phi2;
    logic               flip2;

    // Half angle in Q.30 is the Q.28 angle times two.
    assign phi0 = $signed({3'b000, in_side.theta, 1'b0});

    always_comb
    begin
        phi2  = phi1_reg;
        flip2 = 1'b0;
        if (phi1_reg > rexp_pkg::HALF_PI_Q30)
        begin
            phi2  = phi1_reg - rexp_pkg::PI_Q30;
            flip2 = 1'b1;
        end
        else if (phi1_reg < -rexp_pkg::HALF_PI_Q30)
        begin
            phi2  = phi1_reg + rexp_pkg::PI_Q30;
            flip2 = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg     <= in_valid;
            vld_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phi1_reg    <= (phi0 > rexp_pkg::PI_Q30) ? phi0 - rexp_pkg::TWO_PI_Q30 : phi0;
            side1_reg   <= in_side;
            phi_reg[0]  <= phi2;
            flip_reg[0] <= flip2;
            cx_reg[0]   <= rexp_pkg::GAIN_Q30;
            cy_reg[0]   <= '0;
            side_reg[0] <= side1_reg;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        localparam logic signed [35:0] ATAN = $signed({4'b0000, rexp_pkg::atan_q30(i)});
        logic signed [33:0] dx;
        logic signed [33:0] dy;

        assign dx = cy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (phi_reg[i] >= 0)
                begin
                    cx_reg[i+1]  <= cx_reg[i] - dx;
                    cy_reg[i+1]  <= cy_reg[i] + dy;
                    phi_reg[i+1] <= phi_reg[i] - ATAN;
                end
                else
                begin
                    cx_reg[i+1]  <= cx_reg[i] + dx;
                    cy_reg[i+1]  <= cy_reg[i] - dy;
                    phi_reg[i+1] <= phi_reg[i] + ATAN;
                end
                flip_reg[i+1] <= flip_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_cx_reg   <= flip_reg[N] ? -cx_reg[N] : cx_reg[N];
            out_cy_reg   <= flip_reg[N] ? -cy_reg[N] : cy_reg[N];
            out_side_reg <= side_reg[N];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_cx    = out_cx_reg;
    assign out_cy    = out_cy_reg;
    assign out_side  = out_side_reg;

endmodule

// ===== rtl/rexp_factor.sv =====
// Imaginary factor: small-angle series or a restoring divider for sin of half the angle over theta.
module rexp_factor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [28:0]        thresh,
    input  logic               in_valid,
    input  logic signed [33:0] in_cx,
    input  logic signed [33:0] in_cy,
    input  rexp_pkg::side_t    in_side,
    output logic               out_valid,
    output logic signed [38:0] out_f,
    output logic signed [33:0] out_cx,
    output rexp_pkg::side_t    out_side
);

    localparam int          N  = rexp_pkg::DIV_STEPS;
    localparam logic [31:0] M3  = 32'hAAAAAAAB;
    localparam logic [31:0] M15 = 32'h88888889;

    typedef struct packed {
        logic               ser;
        logic               neg;
        logic signed [33:0] cx;
        rexp_pkg::side_t    side;
    } carry_t;

    logic [33:0] mcy;
    logic [57:0] th_sq;

    logic        v_reg   [4];
    carry_t      c_reg   [4];
    logic [63:0] d_reg   [4];
    logic [31:0] t2_reg;
    logic [33:0] t4_reg;
    logic [61:0] a3_reg;
    logic [59:0] a15_reg;
    logic [28:0] d12_reg;
    logic [32:0] fs_reg;

    logic [31:0] rem_reg [0:N];
    logic [N-1:0] dlo_reg [0:N];
    logic [N-1:0] q_reg  [0:N];
    logic [32:0] fsd_reg [0:N];
    carry_t      cd_reg  [0:N];
    logic        vld_reg [0:N];

    logic               out_valid_reg;
    logic signed [38:0] out_f_reg;
    logic signed [33:0] out_cx_reg;
    rexp_pkg::side_t    out_side_reg;

    assign mcy   = in_cy[33] ? (~in_cy + 34'd1) : in_cy;
    // The series is only taken below a 29-bit threshold, so the low bits of theta suffice.
    assign th_sq = in_side.theta[28:0] * in_side.theta[28:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0]   <= in_valid;
            v_reg[1]   <= v_reg[0];
            v_reg[2]   <= v_reg[1];
            v_reg[3]   <= v_reg[2];
            vld_reg[0] <= v_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg[0].ser  <= (in_side.theta == 32'd0) || (in_side.theta < {3'b000, thresh});
            c_reg[0].neg  <= in_cy[33];
            c_reg[0].cx   <= in_cx;
            c_reg[0].side <= in_side;
            d_reg[0]      <= ({30'd0, mcy} << 30) + {33'd0, in_side.theta[31:1]};
            t2_reg        <= 32'(({1'b0, th_sq} + 59'd33554432) >> 26);

            c_reg[1] <= c_reg[0];
            d_reg[1] <= d_reg[0];
            t4_reg   <= 34'(({32'd0, t2_reg} * {32'd0, t2_reg} + 64'd536870912) >> 30);
            a3_reg   <= {2'b00, t2_reg[31:2]} * M3;

            c_reg[2] <= c_reg[1];
            d_reg[2] <= d_reg[1];
            a15_reg  <= t4_reg[33:6] * M15;
            d12_reg  <= a3_reg[61:33];

            c_reg[3] <= c_reg[2];
            d_reg[3] <= d_reg[2];
            fs_reg   <= 33'd2147483648 - {4'd0, d12_reg} + {8'd0, a15_reg[59:35]};

            cd_reg[0]  <= c_reg[3];
            fsd_reg[0] <= fs_reg;
            rem_reg[0] <= {6'd0, d_reg[3][63:N]};
            dlo_reg[0] <= d_reg[3][N-1:0];
            q_reg[0]   <= '0;
        end
    end

    // Restoring division, one quotient bit per stage; the rounding half is already in the dividend.
    for (genvar j = 0; j < N; j++)
    begin : g_div
        logic [32:0] part;
        logic        take;

        assign part = {rem_reg[j], dlo_reg[j][N-1]};
        assign take = part >= {1'b0, cd_reg[j].side.theta};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= take ? 32'(part - {1'b0, cd_reg[j].side.theta}) : part[31:0];
                dlo_reg[j+1] <= dlo_reg[j] << 1;
                q_reg[j+1]   <= {q_reg[j][N-2:0], take};
                cd_reg[j+1]  <= cd_reg[j];
                fsd_reg[j+1] <= fsd_reg[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (cd_reg[N].ser)
            begin
                out_f_reg <= $signed({6'd0, fsd_reg[N]});
            end
            else if (cd_reg[N].neg)
            begin
                out_f_reg <= -$signed({1'b0, q_reg[N]});
            end
            else
            begin
                out_f_reg <= $signed({1'b0, q_reg[N]});
            end
            out_cx_reg   <= cd_reg[N].cx;
            out_side_reg <= cd_reg[N].side;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_f     = out_f_reg;
    assign out_cx    = out_cx_reg;
    assign out_side  = out_side_reg;

endmodule

// ===== rtl/rexp_scale.sv =====
// Scales the rotation vector by the factor, rounds and clamps the quaternion parts.
module rexp_scale (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [38:0] in_f,
    input  logic signed [33:0] in_cx,
    input  rexp_pkg::side_t    in_side,
    output logic               out_valid,
    output rexp_pkg::result_t  out_res
);

    logic [37:0]        fm;
    logic signed [31:0] om  [3];
    logic [31:0]        omm [3];

    logic        v1_reg;
    logic [63:0] pl_reg  [3];
    logic [37:0] ph_reg  [3];
    logic        neg_reg [3];
    logic [31:0] w_reg;
    logic [31:0] ang_reg;

    logic [31:0] part [3];

    logic              out_valid_reg;
    rexp_pkg::result_t out_res_reg;

    assign fm = in_f[38] ? 38'(-in_f) : in_f[37:0];

    always_comb
    begin
        om[0] = in_side.vec.x;
        om[1] = in_side.vec.y;
        om[2] = in_side.vec.z;
        for (int k = 0; k < 3; k++)
        begin
            omm[k] = om[k][31] ? (~om[k] + 32'd1) : om[k];
        end
    end

    // Second stage: join partial products, round half away from zero, clamp, restore sign.
    for (genvar k = 0; k < 3; k++)
    begin : g_part
        logic [69:0] p;
        logic [39:0] r;
        logic [31:0] m;

        always_comb
        begin
            p = {6'd0, pl_reg[k]} + ({32'd0, ph_reg[k]} << 32);
            r = 40'((p + 70'd536870912) >> 30);
            m = (r > 40'd1073741824) ? 32'd1073741824 : r[31:0];
            part[k] = neg_reg[k] ? (~m + 32'd1) : m;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            out_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pl_reg[k]  <= fm[31:0] * omm[k];
                ph_reg[k]  <= {32'd0, fm[37:32]} * {6'd0, omm[k]};
                neg_reg[k] <= in_f[38] ^ om[k][31];
            end
            if (in_cx > rexp_pkg::ONE_Q30)
            begin
                w_reg <= 32'(rexp_pkg::ONE_Q30);
            end
            else if (in_cx < -rexp_pkg::ONE_Q30)
            begin
                w_reg <= 32'(-rexp_pkg::ONE_Q30);
            end
            else
            begin
                w_reg <= in_cx[31:0];
            end
            ang_reg <= in_side.theta;

            out_res_reg.qw    <= w_reg;
            out_res_reg.qx    <= part[0];
            out_res_reg.qy    <= part[1];
            out_res_reg.qz    <= part[2];
            out_res_reg.angle <= ang_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

// ===== rtl/rotation_exp_map.sv =====
// Top level of the rotation exponential map: rotation vector in, unit quaternion and angle out.
//
// Use: a rotation vector (omega x, y, z, signed Q3.28 radians) enters on the s_axis
// channel as one transaction. One result transaction leaves on m_axis carrying the
// quaternion (w, x, y, z, signed Q1.30) and the angle theta (unsigned Q4.28).
// The small-angle threshold (unsigned Q1.28) is written on the cfg channel, which is
// always ready; write it only while no transaction is in flight.
// Throughput is one transaction per cycle while m_axis is not stalled. A result passes
// through the chain of units in order: squares, sum and the one-bit-per-stage square
// root, range reduction and the 30-stage CORDIC, the small-angle series and the
// 38-stage restoring divider, the scaling multiplies and the output register.
// Every stage advances together whenever the output register is empty or being taken,
// so a stall on m_axis freezes the whole pipeline and nothing is lost or repeated;
// s_axis_tready then drops in the same cycle.
// Reset clears all valid bits, so no result appears until a transaction enters, and
// sets the threshold to one LSB, which selects the series only for a zero angle.
module rotation_exp_map (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // omega_x, omega_y, omega_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,   // quat_w, quat_x, quat_y, quat_z, angle
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [28:0]  cfg_data        // small_angle_threshold
);

    logic en;
    logic [28:0] thresh_reg;

    rexp_pkg::vec_t  in_vec;
    logic            n_valid;
    rexp_pkg::side_t n_side;

    logic               c_valid;
    logic signed [33:0] c_cx;
    logic signed [33:0] c_cy;
    rexp_pkg::side_t    c_side;

    logic               f_valid;
    logic signed [38:0] f_f;
    logic signed [33:0] f_cx;
    rexp_pkg::side_t    f_side;

    logic              s_valid;
    rexp_pkg::result_t s_res;

    logic              m_valid_reg;
    rexp_pkg::result_t m_res_reg;

    // The pipeline moves whenever the output register can take a new word.
    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    assign in_vec.x = s_axis_tdata[31:0];
    assign in_vec.y = s_axis_tdata[63:32];
    assign in_vec.z = s_axis_tdata[95:64];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= 29'd1;
        end
        else if (cfg_valid)
        begin
            thresh_reg <= cfg_data;
        end
    end

    rexp_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .in_vec   (in_vec),
        .out_valid(n_valid),
        .out_side (n_side)
    );

    rexp_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (n_valid),
        .in_side  (n_side),
        .out_valid(c_valid),
        .out_cx   (c_cx),
        .out_cy   (c_cy),
        .out_side (c_side)
    );

    rexp_factor u_factor (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .thresh   (thresh_reg),
        .in_valid (c_valid),
        .in_cx    (c_cx),
        .in_cy    (c_cy),
        .in_side  (c_side),
        .out_valid(f_valid),
        .out_f    (f_f),
        .out_cx   (f_cx),
        .out_side (f_side)
    );

    rexp_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (f_valid),
        .in_f     (f_f),
        .in_cx    (f_cx),
        .in_side  (f_side),
        .out_valid(s_valid),
        .out_res  (s_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_res_reg <= s_res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_res_reg;

endmodule

// ===== rtl/rexp_check.sv =====
// Port-level checker for the rotation exponential map, bound to the top level.
module rexp_check (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [95:0]  s_axis_tdata,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [28:0]  cfg_data
);

    // A held result keeps its value until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // An empty output stage never blocks the input.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // The real part stays inside the clamp range.
    a_wrange: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[31:0]) <= 32'sd1073741824)
            && ($signed(m_axis_tdata[31:0]) >= -32'sd1073741824))
        else $error("quat_w out of range");

    // A zero angle comes only from a zero vector, so the imaginary parts vanish.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[159:128] == 32'd0)
            |-> (m_axis_tdata[127:32] == 96'd0))
        else $error("nonzero imaginary part at zero angle");

endmodule

bind rotation_exp_map rexp_check u_rexp_check (.*);

// ===== test/rexp_checker.sv =====
// Checker for the rotation exponential map: predicts each result and compares it on arrival.
`timescale 1ns / 1ps

module rexp_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [159:0] m_axis_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [28:0]  cfg_data,
    output int           fails,
    output int           pending
);

    localparam longint ARCTAN [30] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
    };
    localparam longint Q30_ONE = 64'sd1073741824;

    logic [28:0]       threshold;
    rexp_pkg::result_t quat_queue [$];

    function automatic longint clamp_unit(input longint v);
        if (v > Q30_ONE)
            return Q30_ONE;
        if (v < -Q30_ONE)
            return -Q30_ONE;
        return v;
    endfunction

    // Exponential map of one rotation vector, bit exact to the hardware arithmetic.
    function automatic rexp_pkg::result_t exp_map(input logic [95:0] data,
                                                  input logic [28:0] thr);
        longint            om [3];
        longint unsigned   mag, sum, res, b, rem, theta, t2, t4, num, q, p;
        longint            phi, cx, cy, dx, dy, f, r;
        bit                flip;
        rexp_pkg::result_t out;
        begin
            sum = 0;
            for (int i = 0; i < 3; i++)
            begin
                om[i] = longint'($signed(data[32*i +: 32]));
                mag = (om[i] < 0) ? longint'(-om[i]) : om[i];
                sum += mag * mag;
            end
            // Integer square root, rounded to nearest.
            res = 0;
            b = 64'h4000000000000000;
            rem = sum;
            while (b > rem)
                b >>= 2;
            while (b != 0)
            begin
                if (rem >= res + b)
                begin
                    rem -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            if (sum - res * res > res)
                res++;
            theta = res;

            // CORDIC on theta/2 in Q.30 after range reduction.
            phi = longint'(theta) * 2;
            flip = 0;
            if (phi > 64'sd3373259426)
                phi -= 64'sd6746518852;
            if (phi > 64'sd1686629713)
            begin
                phi -= 64'sd3373259426;
                flip = 1;
            end
            else if (phi < -64'sd1686629713)
            begin
                phi += 64'sd3373259426;
                flip = 1;
            end
            cx = 64'sd652032874;
            cy = 0;
            for (int i = 0; i < 30; i++)
            begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (phi >= 0)
                begin
                    cx -= dx;
                    cy += dy;
                    phi -= ARCTAN[i];
                end
                else
                begin
                    cx += dx;
                    cy -= dy;
                    phi += ARCTAN[i];
                end
            end
            if (flip)
            begin
                cx = -cx;
                cy = -cy;
            end

            // Imaginary factor in Q.32: the series near zero, the division otherwise.
            if (theta == 0 || theta < longint'(thr))
            begin
                t2 = (theta * theta + (64'd1 << 25)) >> 26;
                t4 = (t2 * t2 + (64'd1 << 29)) >> 30;
                f = longint'(64'd1 << 31) - longint'(t2 / 12) + longint'(t4 / 960);
            end
            else
            begin
                num = ((cy < 0) ? longint'(-cy) : cy);
                num = num << 30;
                q = (num + theta / 2) / theta;
                f = (cy < 0) ? -longint'(q) : longint'(q);
            end

            out.qw = 32'(clamp_unit(cx));
            for (int i = 0; i < 3; i++)
            begin
                mag = (om[i] < 0) ? longint'(-om[i]) : om[i];
                p = ((f < 0) ? longint'(-f) : f);
                p = p * mag;
                r = longint'((p + (64'd1 << 29)) >> 30);
                if ((f < 0) != (om[i] < 0))
                    r = -r;
                r = clamp_unit(r);
                case (i)
                    0: out.qx = r[31:0];
                    1: out.qy = r[31:0];
                    default: out.qz = r[31:0];
                endcase
            end
            out.angle = theta[31:0];
            return out;
        end
    endfunction

    assign pending = quat_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold <= 29'd1;
            fails = 0;
            quat_queue.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                rexp_pkg::result_t got, want;
                got = m_axis_tdata;
                if (quat_queue.size() == 0)
                begin
                    $error("result transaction with nothing expected: %h", m_axis_tdata);
                    fails++;
                end
                else
                begin
                    want = quat_queue.pop_front();
                    if (got.qw !== want.qw)
                    begin
                        $error("quat_w expected %h actual %h", want.qw, got.qw);
                        fails++;
                    end
                    if (got.qx !== want.qx)
                    begin
                        $error("quat_x expected %h actual %h", want.qx, got.qx);
                        fails++;
                    end
                    if (got.qy !== want.qy)
                    begin
                        $error("quat_y expected %h actual %h", want.qy, got.qy);
                        fails++;
                    end
                    if (got.qz !== want.qz)
                    begin
                        $error("quat_z expected %h actual %h", want.qz, got.qz);
                        fails++;
                    end
                    if (got.angle !== want.angle)
                    begin
                        $error("angle expected %h actual %h", want.angle, got.angle);
                        fails++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                quat_queue.push_back(exp_map(s_axis_tdata, threshold));
            if (cfg_valid && cfg_ready)
                threshold <= cfg_data;
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the rotation exponential map testbench: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [159:0] m_axis_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [28:0]  cfg_data = '0;

    int  fails;
    int  pending;
    int  cycles = 0;
    int  burst_left = 0;
    // Set by the pressure process; the receiver stays stalled while it is high.
    logic hold_off = 1'b0;
    // Raised by the stimulus at the start of its longest phase.
    logic pressure_go = 1'b0;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int LATENCY     = 115;

    always #10 clk = ~clk;

    rotation_exp_map uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    rexp_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fails         (fails),
        .pending       (pending)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("rotation_exp_map regression: fail");
            $finish;
        end
    end

    // The receiver switches among several stall patterns, including long runs of
    // full readiness, so that stalls land on every phase of the pipeline.
    initial
    begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            if (hold_off)
                m_axis_tready <= 1'b0;
            else
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2: m_axis_tready <= ($urandom_range(0, 7) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
        end
    end

    // Pressure: once the longest phase starts, the receiver is held off for a long
    // stretch while the sender keeps offering transactions, so the pipeline fills.
    initial
    begin
        wait (pressure_go);
        hold_off <= 1'b1;
        repeat (600) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Offers one rotation vector and waits for its transaction. The valid line is
    // only lowered when a gap follows, so it never toggles twice in one step.
    task automatic send_vec(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        int gap;
        if (burst_left == 0)
            burst_left = $urandom_range(1, 40);
        s_axis_tdata <= {z, y, x};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // A component spread over all magnitudes so that tiny and huge angles both occur.
    function automatic logic [31:0] rand_comp();
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, 31);
    endfunction

    task automatic random_vecs(input int count);
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        int          shape;
        for (int i = 0; i < count; i++)
        begin
            shape = $urandom_range(0, 3);
            x = rand_comp();
            y = rand_comp();
            z = rand_comp();
            if (shape == 0)
            begin
                x = $urandom;
                y = $urandom;
                z = $urandom;
            end
            else if (shape == 1)
            begin
                // Zero y, and z zero in some of them too, so single-axis rotations occur.
                y = 32'd0;
                z = ($urandom_range(0, 1) == 1) ? 32'd0 : z;
            end
            send_vec(x, y, z);
        end
    endtask

    // Threshold writes happen only with the pipeline drained.
    task automatic write_threshold(input logic [28:0] value);
        if (s_axis_tvalid)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        burst_left = 0;
        wait (pending == 0);
        repeat (LATENCY + 10) @(posedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed vectors under the reset threshold: zero, unit steps, extremes,
        // angles around pi and two pi, and the all-minimum vector.
        send_vec(32'd0, 32'd0, 32'd0);
        send_vec(32'd1, 32'd0, 32'd0);
        send_vec(32'd0, 32'hFFFFFFFF, 32'd0);
        send_vec(32'd0, 32'd0, 32'd2);
        send_vec(32'h7FFFFFFF, 32'd0, 32'd0);
        send_vec(32'h80000000, 32'd0, 32'd0);
        send_vec(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_vec(32'h80000000, 32'h80000000, 32'h80000000);
        send_vec(32'd843314857, 32'd0, 32'd0);
        send_vec(32'd0, -32'sd843314857, 32'd0);
        send_vec(32'd421657428, 32'd0, 32'd0);
        send_vec(32'd0, 32'd0, 32'd1686629713);
        send_vec(32'd1686629714, 32'd0, 32'd0);
        send_vec(32'h10000000, 32'h10000000, 32'hF0000000);
        random_vecs(60);

        // Threshold zero: only a zero angle takes the series.
        write_threshold(29'd0);
        send_vec(32'd0, 32'd0, 32'd0);
        send_vec(32'd1, 32'd1, 32'd1);
        random_vecs(60);

        // Largest threshold: almost every angle below two takes the series.
        write_threshold(29'h1FFFFFFF);
        send_vec(32'h1FFFFFFE, 32'd0, 32'd0);
        send_vec(32'h1FFFFFFF, 32'd0, 32'd0);
        send_vec(32'h20000000, 32'd0, 32'd0);
        random_vecs(60);

        // One radian.
        write_threshold(29'h10000000);
        send_vec(32'h0FFFFFFF, 32'd0, 32'd0);
        send_vec(32'h10000000, 32'd0, 32'd0);
        random_vecs(60);

        // A small threshold, near where the series and the division meet.
        write_threshold(29'h00100000);
        send_vec(32'h000FFFFF, 32'd0, 32'd0);
        send_vec(32'd0, 32'hFFF00000, 32'd0);
        random_vecs(60);

        // The longest phase runs under the long receiver stall, so it holds more
        // transactions than the pipeline can.
        write_threshold(29'($urandom));
        pressure_go <= 1'b1;
        random_vecs(160);

        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (fails == 0)
            $display("rotation_exp_map regression: pass");
        else
            $display("rotation_exp_map regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rexp_pkg.sv
rtl/rexp_norm.sv
rtl/rexp_cordic.sv
rtl/rexp_factor.sv
rtl/rexp_scale.sv
rtl/rotation_exp_map.sv
rtl/rexp_check.sv
test/rexp_checker.sv
test/tb_top.sv
